FILE: design/jmsp_pkg.sv
// Shared types and constants for the JPEG marker segment parser.
`default_nettype none

package jmsp_pkg;

   // Parser phase
   typedef enum logic [3:0] {
      PH_START0,
      PH_START1,
      PH_MARK0,
      PH_MARK1,
      PH_LEN0,
      PH_LEN1,
      PH_PAYLOAD,
      PH_SCAN,
      PH_SCAN_FF,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_START   = 3'd1;
   localparam logic [2:0] ERR_NOT_MARKER  = 3'd2;
   localparam logic [2:0] ERR_EARLY_EOI   = 3'd3;
   localparam logic [2:0] ERR_REPEAT_SOI  = 3'd4;
   localparam logic [2:0] ERR_BAD_LENGTH  = 3'd5;
   localparam logic [2:0] ERR_STRAY_SCAN  = 3'd6;

   // Byte values of interest
   localparam logic [7:0] BYTE_FF     = 8'hFF;
   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] MARKER_SOI  = 8'hD8;
   localparam logic [7:0] MARKER_EOI  = 8'hD9;
   localparam logic [7:0] MARKER_SOS  = 8'hDA;
   localparam logic [3:0] APP_NIBBLE  = 4'hE;

   // Length field includes its own two bytes
   localparam logic [15:0] LEN_SELF   = 16'd2;

   // One result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  marker_code;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        in_scan;
      logic [2:0]  error_code;
   } result_type;

endpackage

`default_nettype wire

FILE: design/jmsp_parse.sv
// Segment parser state machine: per-byte decision, state and result formation.
`default_nettype none

module jmsp_parse
   import jmsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] data_byte,
   input  wire logic       step,
   output logic            has_result,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic        skip_ff, skip_in;
   logic [2:0]  err_ff, err_in;

   logic [15:0] seg_len;
   logic [15:0] bytes_dec;
   logic        len_bad;

   assign seg_len   = {len_hi_ff, data_byte};
   assign len_bad   = (seg_len <= LEN_SELF);
   assign bytes_dec = bytes_ff - 16'd1;

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      marker_in = marker_ff;
      bytes_in  = bytes_ff;
      len_hi_in = len_hi_ff;
      skip_in   = skip_ff;
      err_in    = err_ff;
      case (phase_ff)
         PH_START0: begin
            if (data_byte != BYTE_FF) begin
               phase_in = PH_ERROR;
               err_in   = ERR_BAD_START;
            end else begin
               phase_in = PH_START1;
            end
         end
         PH_START1: begin
            if (data_byte != MARKER_SOI) begin
               phase_in = PH_ERROR;
               err_in   = ERR_BAD_START;
            end else begin
               phase_in = PH_MARK0;
            end
         end
         PH_MARK0: begin
            if (data_byte != BYTE_FF) begin
               phase_in = PH_ERROR;
               err_in   = ERR_NOT_MARKER;
            end else begin
               phase_in = PH_MARK1;
            end
         end
         PH_MARK1: begin
            if (data_byte == MARKER_EOI) begin
               phase_in = PH_ERROR;
               err_in   = ERR_EARLY_EOI;
            end else if (data_byte == MARKER_SOI) begin
               phase_in = PH_ERROR;
               err_in   = ERR_REPEAT_SOI;
            end else begin
               marker_in = data_byte;
               skip_in   = (data_byte[7:4] == APP_NIBBLE);
               phase_in  = PH_LEN0;
            end
         end
         PH_LEN0: begin
            len_hi_in = data_byte;
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            if (len_bad) begin
               phase_in = PH_ERROR;
               err_in   = ERR_BAD_LENGTH;
            end else begin
               bytes_in = seg_len - LEN_SELF;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            bytes_in = bytes_dec;
            if (bytes_dec == 16'd0) begin
               phase_in = (marker_ff == MARKER_SOS) ? PH_SCAN : PH_MARK0;
            end
         end
         PH_SCAN: begin
            if (data_byte == BYTE_FF) begin
               phase_in = PH_SCAN_FF;
            end
         end
         PH_SCAN_FF: begin
            if (data_byte == BYTE_ZERO) begin
               phase_in = PH_SCAN;
            end else if (data_byte == MARKER_EOI) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_ERROR;
               err_in   = ERR_STRAY_SCAN;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   // Result for the current byte
   always_comb begin
      has_result = 1'b0;
      result     = '0;
      case (phase_ff)
         PH_START0, PH_START1, PH_MARK0, PH_MARK1, PH_LEN1, PH_SCAN_FF: begin
            // Any failure here shows as a move into the error phase
            if (phase_in == PH_ERROR) begin
               has_result        = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = err_in;
            end else if (phase_ff == PH_LEN1) begin
               has_result            = !skip_ff;
               result.kind           = KIND_HEADER;
               result.marker_code    = marker_ff;
               result.payload_length = bytes_in;
            end else if (phase_ff == PH_SCAN_FF) begin
               has_result = 1'b1;
               if (phase_in == PH_DONE) begin
                  result.kind        = KIND_END;
                  result.marker_code = MARKER_EOI;
               end else begin
                  result.kind         = KIND_PAYLOAD;
                  result.marker_code  = marker_ff;
                  result.payload_byte = BYTE_FF;
                  result.in_scan      = 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            has_result          = !skip_ff;
            result.kind         = KIND_PAYLOAD;
            result.marker_code  = marker_ff;
            result.payload_byte = data_byte;
         end
         PH_SCAN: begin
            has_result          = (data_byte != BYTE_FF);
            result.kind         = KIND_PAYLOAD;
            result.marker_code  = marker_ff;
            result.payload_byte = data_byte;
            result.in_scan      = 1'b1;
         end
         PH_LEN0, PH_DONE: begin
            has_result = 1'b0;
         end
         default: begin
            // Error phase repeats the sticky code
            has_result        = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = err_ff;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START0;
         marker_ff <= 8'd0;
         bytes_ff  <= 16'd0;
         len_hi_ff <= 8'd0;
         skip_ff   <= 1'b0;
         err_ff    <= ERR_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         marker_ff <= marker_in;
         bytes_ff  <= bytes_in;
         len_hi_ff <= len_hi_in;
         skip_ff   <= skip_in;
         err_ff    <= err_in;
      end
   end

`ifndef SYNTHESIS
   // Error phase always carries a real error code
   a_err_code_set: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |-> (err_ff != ERR_NONE))
      else $error("error phase with no error code");

   // Once in error, the parser never leaves it
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |=> (phase_ff == PH_ERROR))
      else $error("left error phase without reset");

   // Payload counter never sits at zero while payload bytes are expected
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (bytes_ff != 16'd0))
      else $error("payload phase with zero bytes left");
`endif

endmodule

`default_nettype wire

FILE: design/jpeg_marker_segment_parser_top.sv
// Top level of the JPEG marker segment parser: input register, parser, result register.
// One file byte is accepted per cycle unless a held result stalls it, and each byte gives
// zero or one result. A byte waits in the input register, is parsed there by the segment
// state machine, and its result is loaded into the result register when the byte moves
// on. Bytes that give no result (start bytes, marker bytes, length high byte, APPn
// contents, the FF of a stuffed pair) move on even while a result waits, and a held result
// stalls only bytes that would produce one. Errors are sticky until reset; after end of
// image all bytes are taken and dropped.
`default_nettype none

module jpeg_marker_segment_parser_top
   import jmsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_marker_code,
   output logic [15:0]      rsp_payload_length,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_in_scan,
   output logic [2:0]       rsp_error_code
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;

   logic       has_result;
   result_type result;
   logic       advance;
   logic       out_free;

   // Result slot can take a new result this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || advance;

   jmsp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (in_byte_ff),
      .step       (advance),
      .has_result (has_result),
      .result     (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_marker_code    = out_ff.marker_code;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_in_scan        = out_ff.in_scan;
   assign rsp_error_code     = out_ff.error_code;

`ifndef SYNTHESIS
   // Error results always carry a code, other results never do
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.kind == KIND_ERROR) == (out_ff.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // After an error result is delivered, any later result is an error too
   a_err_follow: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ready && (out_ff.kind == KIND_ERROR))
      |=> (!out_valid_ff || (out_ff.kind == KIND_ERROR)))
      else $error("non-error result after an error");

   // Scan flag only on payload results
   a_scan_kind: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.in_scan) |-> (out_ff.kind == KIND_PAYLOAD))
      else $error("scan flag on a non-payload result");

   // A parsed byte with a result never moves while the result slot is blocked
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result) |-> out_free)
      else $error("result register overrun");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the JPEG marker segment parser: byte stream in, segment results out.
`timescale 1ns / 100ps

module tb_top
   import jmsp_pkg::*;
();

   // Marker codes used by the stimulus
   localparam logic [7:0] MARKER_DHT  = 8'hC4;
   localparam logic [7:0] MARKER_APP0 = 8'hE0;
   localparam logic [7:0] MARKER_APP15 = 8'hEF;
   localparam logic [7:0] MARKER_RST0 = 8'hD0;
   localparam logic [7:0] CODE_ZERO   = 8'h00;

   localparam int STUCK_LIMIT = 2000;

   // How the image stream ends; errors are sticky and reset comes once, so one per run
   typedef enum int {
      FIN_CLEAN,
      FIN_STRAY,
      FIN_NOT_MARKER,
      FIN_EARLY_EOI,
      FIN_REPEAT_SOI,
      FIN_BAD_LENGTH,
      FIN_BAD_START
   } ending_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_marker_code;
   logic [15:0] rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_in_scan;
   logic [2:0]  rsp_error_code;

   // Parser state as tracked by the bench
   phase_type   ph = PH_START0;
   logic [7:0]  cur_marker = 8'h00;
   logic [15:0] seg_left = 16'h0000;
   logic [7:0]  len_hi = 8'h00;
   logic        skip_app = 1'b0;
   logic [2:0]  sticky_err = ERR_NONE;

   result_type  pending_results[$];
   int          mismatch_count = 0;
   int          result_index = 0;
   int          sent_count = 0;
   int          stall_left = 0;
   int          stuck_cycles = 0;
   bit          no_idle = 1'b0;
   ending_type  ending;

   jpeg_marker_segment_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_marker_code    (rsp_marker_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_in_scan        (rsp_in_scan),
      .rsp_error_code     (rsp_error_code)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_result(input logic [1:0] k, input logic [7:0] code,
                                        input logic [15:0] plen, input logic [7:0] pbyte,
                                        input logic scan, input logic [2:0] err);
      result_type r;
      r.kind           = k;
      r.marker_code    = code;
      r.payload_length = plen;
      r.payload_byte   = pbyte;
      r.in_scan        = scan;
      r.error_code     = err;
      pending_results = {pending_results, r};
   endfunction

   function automatic void enter_error(input logic [2:0] err);
      sticky_err = err;
      ph = PH_ERROR;
      queue_result(KIND_ERROR, 8'h00, 16'h0000, 8'h00, 1'b0, sticky_err);
   endfunction

   // Advance the tracked parser by one accepted byte and queue what it must emit
   function automatic void parse_next_byte(input logic [7:0] b);
      logic [15:0] seg_len;
      seg_len = {len_hi, b};
      case (ph)
         PH_START0:
            if (b == BYTE_FF) ph = PH_START1;
            else enter_error(ERR_BAD_START);
         PH_START1:
            if (b == MARKER_SOI) ph = PH_MARK0;
            else enter_error(ERR_BAD_START);
         PH_MARK0:
            if (b == BYTE_FF) ph = PH_MARK1;
            else enter_error(ERR_NOT_MARKER);
         PH_MARK1: begin
            if (b == MARKER_EOI) enter_error(ERR_EARLY_EOI);
            else if (b == MARKER_SOI) enter_error(ERR_REPEAT_SOI);
            else begin
               cur_marker = b;
               skip_app = (b[7:4] == APP_NIBBLE);
               ph = PH_LEN0;
            end
         end
         PH_LEN0: begin
            len_hi = b;
            ph = PH_LEN1;
         end
         PH_LEN1: begin
            if (seg_len <= LEN_SELF) enter_error(ERR_BAD_LENGTH);
            else begin
               seg_left = seg_len - LEN_SELF;
               ph = PH_PAYLOAD;
               if (!skip_app)
                  queue_result(KIND_HEADER, cur_marker, seg_left, 8'h00, 1'b0, ERR_NONE);
            end
         end
         PH_PAYLOAD: begin
            seg_left = seg_left - 16'd1;
            if (seg_left == 16'd0) ph = (cur_marker == MARKER_SOS) ? PH_SCAN : PH_MARK0;
            if (!skip_app)
               queue_result(KIND_PAYLOAD, cur_marker, 16'h0000, b, 1'b0, ERR_NONE);
         end
         PH_SCAN:
            if (b == BYTE_FF) ph = PH_SCAN_FF;
            else queue_result(KIND_PAYLOAD, cur_marker, 16'h0000, b, 1'b1, ERR_NONE);
         PH_SCAN_FF: begin
            // stuffed FF 00 gives one FF; FF D9 closes the image
            if (b == BYTE_ZERO) begin
               ph = PH_SCAN;
               queue_result(KIND_PAYLOAD, cur_marker, 16'h0000, BYTE_FF, 1'b1, ERR_NONE);
            end else if (b == MARKER_EOI) begin
               ph = PH_DONE;
               queue_result(KIND_END, MARKER_EOI, 16'h0000, 8'h00, 1'b0, ERR_NONE);
            end else begin
               enter_error(ERR_STRAY_SCAN);
            end
         end
         PH_DONE: ;
         default: queue_result(KIND_ERROR, 8'h00, 16'h0000, 8'h00, 1'b0, sticky_err);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) $display("%0t result %0d mismatch: %s", $time, result_index, what);
      mismatch_count++;
   endtask

   // Predict on accepted requests, check each accepted result against the oldest prediction
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) parse_next_byte(req_data_byte);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_marker_code, rsp_payload_length, rsp_payload_byte,
                   rsp_in_scan, rsp_error_code};
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", got));
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
               if (got.marker_code !== want.marker_code)
                  report_mismatch($sformatf("marker_code %h, want %h",
                                            got.marker_code, want.marker_code));
               if (got.payload_length !== want.payload_length)
                  report_mismatch($sformatf("payload_length %0d, want %0d",
                                            got.payload_length, want.payload_length));
               if (got.payload_byte !== want.payload_byte)
                  report_mismatch($sformatf("payload_byte %h, want %h",
                                            got.payload_byte, want.payload_byte));
               if (got.in_scan !== want.in_scan)
                  report_mismatch($sformatf("in_scan %b, want %b", got.in_scan, want.in_scan));
               if (got.error_code !== want.error_code)
                  report_mismatch($sformatf("error_code %0d, want %0d",
                                            got.error_code, want.error_code));
            end
            result_index++;
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Watchdog: too long without any request or result moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Payload bytes lean toward the extremes
   function automatic logic [7:0] payload_value();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Any segment code that is neither SOI, EOI, SOS nor APPn
   function automatic logic [7:0] plain_code();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == MARKER_SOI || v == MARKER_EOI || v == MARKER_SOS || v[7:4] == APP_NIBBLE);
      return v;
   endfunction

   function automatic logic [7:0] segment_code();
      if ($urandom_range(0, 3) == 0) return {APP_NIBBLE, 4'($urandom_range(0, 15))};
      return plain_code();
   endfunction

   function automatic logic [15:0] segment_length();
      if ($urandom_range(0, 9) != 0) return 16'($urandom_range(3, 16));
      return 16'($urandom_range(17, 40));
   endfunction

   task automatic send_marker_length(input logic [7:0] code, input logic [15:0] seg_len);
      send_byte(BYTE_FF);
      send_byte(code);
      send_byte(seg_len[15:8]);
      send_byte(seg_len[7:0]);
   endtask

   task automatic send_segment(input logic [7:0] code, input logic [15:0] seg_len);
      send_marker_length(code, seg_len);
      for (int i = 2; i < seg_len; i++) send_byte(payload_value());
   endtask

   // SOI, or a broken start when the run ends that way
   task automatic test_image_start();
      logic [7:0] v;
      if (ending != FIN_BAD_START) begin
         send_byte(BYTE_FF);
         send_byte(MARKER_SOI);
      end else if ($urandom_range(0, 1) == 0) begin
         send_byte(8'($urandom_range(0, 254)));
      end else begin
         v = 8'($urandom_range(0, 254));
         if (v >= MARKER_SOI) v = v + 8'd1;
         send_byte(BYTE_FF);
         send_byte(v);
      end
   endtask

   // Code extremes, shortest length, APPn bounds, payload extremes
   task automatic test_directed_segments();
      send_segment(CODE_ZERO, 16'd3);
      send_segment(BYTE_FF, 16'd3);
      send_segment(MARKER_APP0, 16'd3);
      send_segment(MARKER_APP15, 16'd4);
      send_marker_length(MARKER_DHT, 16'd4);
      send_byte(BYTE_ZERO);
      send_byte(BYTE_FF);
   endtask

   // Long segment with the length high byte set, streamed with no idling
   task automatic test_max_length_segment();
      no_idle = 1'b1;
      send_segment(plain_code(), 16'h0100);
      no_idle = 1'b0;
   endtask

   task automatic test_random_segments();
      int start;
      bit drained;
      start = sent_count;
      drained = 1'b0;
      while (sent_count - start < 50) begin
         no_idle = ($urandom_range(0, 4) == 0);
         send_segment(segment_code(), segment_length());
         if (!drained && sent_count - start >= 25) begin
            pause_until_drained();
            drained = 1'b1;
         end
      end
      no_idle = 1'b0;
   endtask

   // Entropy-coded data with stuffed FF 00 pairs; sometimes empty
   task automatic test_scan_data();
      int n;
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(30, 60);
      for (int i = 0; i < n; i++) begin
         if (i % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) begin
            send_byte(BYTE_FF);
            send_byte(BYTE_ZERO);
         end else begin
            send_byte(8'($urandom_range(0, 254)));
         end
      end
      no_idle = 1'b0;
   endtask

   // Close the stream: clean EOI or one of the errors after the start
   task automatic test_image_end();
      logic [7:0] v;
      case (ending)
         FIN_CLEAN, FIN_STRAY: begin
            send_segment(MARKER_SOS, 16'($urandom_range(3, 12)));
            test_scan_data();
            send_byte(BYTE_FF);
            if (ending == FIN_CLEAN) begin
               send_byte(MARKER_EOI);
            end else if ($urandom_range(0, 1) == 0) begin
               send_byte(MARKER_RST0 + 8'($urandom_range(0, 7)));
            end else begin
               do v = 8'($urandom_range(0, 255));
               while (v == BYTE_ZERO || v == MARKER_EOI);
               send_byte(v);
            end
         end
         FIN_NOT_MARKER: send_byte(8'($urandom_range(0, 254)));
         FIN_EARLY_EOI: begin
            send_byte(BYTE_FF);
            send_byte(MARKER_EOI);
         end
         FIN_REPEAT_SOI: begin
            send_byte(BYTE_FF);
            send_byte(MARKER_SOI);
         end
         FIN_BAD_LENGTH: send_marker_length(segment_code(), 16'($urandom_range(0, 2)));
         default: ;
      endcase
   endtask

   // Bytes after the end: dropped after EOI, sticky error results otherwise
   task automatic test_trailing_bytes(input int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   function automatic ending_type pick_ending();
      int r;
      r = $urandom_range(0, 11);
      case (r)
         0: return FIN_BAD_START;
         1: return FIN_NOT_MARKER;
         2: return FIN_EARLY_EOI;
         3: return FIN_REPEAT_SOI;
         4: return FIN_BAD_LENGTH;
         5, 6, 7: return FIN_STRAY;
         default: return FIN_CLEAN;
      endcase
   endfunction

   initial begin
      ending = pick_ending();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_image_start();
      if (ending != FIN_BAD_START) begin
         test_directed_segments();
         test_max_length_segment();
         test_random_segments();
         test_image_end();
      end
      test_trailing_bytes((ending == FIN_BAD_START) ? 400 : 20);

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/jmsp_pkg.sv
design/jmsp_parse.sv
design/jpeg_marker_segment_parser_top.sv
bench/tb_top.sv
